// File: design/qefi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qefi_pkg
// Shared types, constants and modular helpers for the GF(p^4) inverse
// pipeline, p = 2^31 - 2^24 + 1.
// ----------------------------------------------------------------------------
package qefi_pkg;

    typedef logic [30:0] t_fe;

    typedef struct packed {
        t_fe        a0;
        t_fe        a1;
        t_fe        a2;
        t_fe        a3;
        logic [1:0] coord;
    } t_elem;

    typedef struct packed {
        t_fe n0;
        t_fe n1;
    } t_norm;

    localparam logic [63:0] FIELD_P   = 64'd2130706433;
    localparam logic [63:0] FIELD_W   = 64'd3;
    localparam t_fe         EXP_E     = 31'(FIELD_P - 64'd2);
    localparam int          EXP_BITS  = 31;
    localparam int          MM_LAT    = 3;
    localparam int          NORM_LAT  = 2 * MM_LAT + 2;
    localparam int          EXP_LAT   = EXP_BITS * MM_LAT;
    localparam int          FIN_LAT   = 2 * MM_LAT + 2;
    localparam int          ELEM_DLY  = NORM_LAT + EXP_LAT;
    localparam int          PIPE_LAT  = 2 + NORM_LAT + EXP_LAT + FIN_LAT;

    // One fold of the high part, using 2^31 = 2^24 - 1 (mod p).
    function automatic logic [63:0] fold(input logic [63:0] x);
        logic [63:0] h;
        h    = x >> 31;
        fold = {33'd0, x[30:0]} + (h << 24) - h;
    endfunction

    // Final correction for a value below 2p.
    function automatic t_fe csub(input logic [63:0] x);
        logic [63:0] y;
        y    = (x >= FIELD_P) ? (x - FIELD_P) : x;
        csub = y[30:0];
    endfunction

    // Reduction of a value below 2^36.
    function automatic t_fe red_small(input logic [63:0] x);
        red_small = csub(fold(fold(x)));
    endfunction

    function automatic t_fe fneg(input t_fe x);
        logic [63:0] y;
        y    = FIELD_P - {33'd0, x};
        fneg = (x == '0) ? '0 : y[30:0];
    endfunction

    function automatic logic [63:0] ext(input t_fe x);
        ext = {33'd0, x};
    endfunction

endpackage
`default_nettype wire

// File: design/qefi_modmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qefi_modmul
// Three-stage modular multiplier: product, then two folding stages with a
// final conditional subtract.
// ----------------------------------------------------------------------------
module qefi_modmul (
    input  wire               i_clk,
    input  wire               i_en,
    input  qefi_pkg::t_fe     i_a,
    input  qefi_pkg::t_fe     i_b,
    output qefi_pkg::t_fe     o_r
);
    import qefi_pkg::*;

    logic [61:0] r_prod;
    logic [43:0] r_x;
    t_fe         r_res;
    logic [43:0] n_x;
    t_fe         n_res;

    always_comb begin
        logic [63:0] t;
        t     = fold(fold(fold({2'b00, r_prod})));
        n_x   = t[43:0];
        n_res = csub(fold(fold(fold({20'd0, r_x}))));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 62'(i_a) * 62'(i_b);
            r_x    <= n_x;
            r_res  <= n_res;
        end
    end

    assign o_r = r_res;

endmodule
`default_nettype wire

// File: design/qefi_norm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qefi_norm
// Computes the norm N = n0 + n1*Y of the element into the quadratic subfield
// and the base-field value d = n0^2 - 3*n1^2.
// ----------------------------------------------------------------------------
module qefi_norm (
    input  wire               i_clk,
    input  wire               i_en,
    input  qefi_pkg::t_elem   i_elem,
    output qefi_pkg::t_norm   o_norm,
    output qefi_pkg::t_fe     o_d
);
    import qefi_pkg::*;

    t_fe   w_p00, w_p22, w_p13, w_p02, w_p11, w_p33, w_q0, w_q1;
    t_norm r_n;
    t_norm r_nd [0:MM_LAT];
    t_fe   r_d;

    qefi_modmul u_p00 (.i_clk, .i_en, .i_a(i_elem.a0), .i_b(i_elem.a0), .o_r(w_p00));
    qefi_modmul u_p22 (.i_clk, .i_en, .i_a(i_elem.a2), .i_b(i_elem.a2), .o_r(w_p22));
    qefi_modmul u_p13 (.i_clk, .i_en, .i_a(i_elem.a1), .i_b(i_elem.a3), .o_r(w_p13));
    qefi_modmul u_p02 (.i_clk, .i_en, .i_a(i_elem.a0), .i_b(i_elem.a2), .o_r(w_p02));
    qefi_modmul u_p11 (.i_clk, .i_en, .i_a(i_elem.a1), .i_b(i_elem.a1), .o_r(w_p11));
    qefi_modmul u_p33 (.i_clk, .i_en, .i_a(i_elem.a3), .i_b(i_elem.a3), .o_r(w_p33));

    qefi_modmul u_q0 (.i_clk, .i_en, .i_a(r_n.n0), .i_b(r_n.n0), .o_r(w_q0));
    qefi_modmul u_q1 (.i_clk, .i_en, .i_a(r_n.n1), .i_b(r_n.n1), .o_r(w_q1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n.n0 <= red_small(ext(w_p00) + ext(w_p22) * FIELD_W
                                + (FIELD_P - ext(w_p13)) * 64'd2 * FIELD_W);
            r_n.n1 <= red_small(ext(w_p02) * 64'd2 + (FIELD_P - ext(w_p11))
                                + (FIELD_P - ext(w_p33)) * FIELD_W);
            r_nd[0] <= r_n;
            for (int i = 1; i <= MM_LAT; i++) begin
                r_nd[i] <= r_nd[i-1];
            end
            r_d <= red_small(ext(w_q0) + (FIELD_P - ext(w_q1)) * FIELD_W);
        end
    end

    assign o_norm = r_nd[MM_LAT];
    assign o_d    = r_d;

endmodule
`default_nettype wire

// File: design/qefi_finv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qefi_finv
// Pipelined base-field inverse d^(p-2): one conditional multiply per exponent
// bit and one square per bit but the last, least significant bit first.
// ----------------------------------------------------------------------------
module qefi_finv (
    input  wire               i_clk,
    input  wire               i_en,
    input  qefi_pkg::t_fe     i_d,
    output qefi_pkg::t_fe     o_di
);
    import qefi_pkg::*;

    t_fe w_acc [0:EXP_BITS];
    t_fe w_sq  [0:EXP_BITS-1];

    assign w_acc[0] = 31'd1;
    assign w_sq[0]  = i_d;

    for (genvar k = 0; k < EXP_BITS; k++) begin : g_bit
        qefi_modmul u_acc (
            .i_clk,
            .i_en,
            .i_a (w_acc[k]),
            .i_b (EXP_E[k] ? w_sq[k] : 31'd1),
            .o_r (w_acc[k+1])
        );
        if (k < EXP_BITS - 1) begin : g_sq
            qefi_modmul u_sq (
                .i_clk,
                .i_en,
                .i_a (w_sq[k]),
                .i_b (w_sq[k]),
                .o_r (w_sq[k+1])
            );
        end
    end

    assign o_di = w_acc[EXP_BITS];

endmodule
`default_nettype wire

// File: design/qefi_final.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qefi_final
// Forms the inverse norm, multiplies the even and odd halves by it and
// negates the odd half; presents the coefficient chosen by the selector.
// ----------------------------------------------------------------------------
module qefi_final (
    input  wire               i_clk,
    input  wire               i_en,
    input  qefi_pkg::t_elem   i_elem,
    input  qefi_pkg::t_norm   i_norm,
    input  qefi_pkg::t_fe     i_di,
    output qefi_pkg::t_fe     o_inv0,
    output qefi_pkg::t_fe     o_inv1,
    output qefi_pkg::t_fe     o_inv2,
    output qefi_pkg::t_fe     o_inv3,
    output qefi_pkg::t_fe     o_sel
);
    import qefi_pkg::*;

    t_fe   w_m0, w_m1;
    t_fe   r_k0, r_k1;
    t_elem r_ed [0:2*MM_LAT];
    t_fe   w_e00, w_e21, w_e01, w_e20, w_o10, w_o31, w_o11, w_o30;
    t_fe   r_inv0, r_inv1, r_inv2, r_inv3, r_sel;
    t_fe   n_inv0, n_inv1, n_inv2, n_inv3, n_sel;

    qefi_modmul u_m0 (.i_clk, .i_en, .i_a(i_norm.n0), .i_b(i_di), .o_r(w_m0));
    qefi_modmul u_m1 (.i_clk, .i_en, .i_a(i_norm.n1), .i_b(i_di), .o_r(w_m1));

    qefi_modmul u_e00 (.i_clk, .i_en, .i_a(r_ed[MM_LAT].a0), .i_b(r_k0), .o_r(w_e00));
    qefi_modmul u_e21 (.i_clk, .i_en, .i_a(r_ed[MM_LAT].a2), .i_b(r_k1), .o_r(w_e21));
    qefi_modmul u_e01 (.i_clk, .i_en, .i_a(r_ed[MM_LAT].a0), .i_b(r_k1), .o_r(w_e01));
    qefi_modmul u_e20 (.i_clk, .i_en, .i_a(r_ed[MM_LAT].a2), .i_b(r_k0), .o_r(w_e20));
    qefi_modmul u_o10 (.i_clk, .i_en, .i_a(r_ed[MM_LAT].a1), .i_b(r_k0), .o_r(w_o10));
    qefi_modmul u_o31 (.i_clk, .i_en, .i_a(r_ed[MM_LAT].a3), .i_b(r_k1), .o_r(w_o31));
    qefi_modmul u_o11 (.i_clk, .i_en, .i_a(r_ed[MM_LAT].a1), .i_b(r_k1), .o_r(w_o11));
    qefi_modmul u_o30 (.i_clk, .i_en, .i_a(r_ed[MM_LAT].a3), .i_b(r_k0), .o_r(w_o30));

    always_comb begin
        n_inv0 = red_small(ext(w_e00) + ext(w_e21) * FIELD_W);
        n_inv2 = red_small(ext(w_e01) + ext(w_e20));
        n_inv1 = fneg(red_small(ext(w_o10) + ext(w_o31) * FIELD_W));
        n_inv3 = fneg(red_small(ext(w_o11) + ext(w_o30)));
        unique case (r_ed[2*MM_LAT].coord)
            2'd0:    n_sel = n_inv0;
            2'd1:    n_sel = n_inv1;
            2'd2:    n_sel = n_inv2;
            default: n_sel = n_inv3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k0  <= w_m0;
            r_k1  <= fneg(w_m1);
            r_ed[0] <= i_elem;
            for (int i = 1; i <= 2 * MM_LAT; i++) begin
                r_ed[i] <= r_ed[i-1];
            end
            r_inv0 <= n_inv0;
            r_inv1 <= n_inv1;
            r_inv2 <= n_inv2;
            r_inv3 <= n_inv3;
            r_sel  <= n_sel;
        end
    end

    assign o_inv0 = r_inv0;
    assign o_inv1 = r_inv1;
    assign o_inv2 = r_inv2;
    assign o_inv3 = r_inv3;
    assign o_sel  = r_sel;

endmodule
`default_nettype wire

// File: design/quartic_ext_field_inverse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quartic_ext_field_inverse
// Streaming inverse in GF(p^4) = GF(p)[X]/(X^4 - 3), p = 2^31 - 2^24 + 1.
// ----------------------------------------------------------------------------
// The block accepts one request per clock while the output side does not
// stall, and returns one result per request, in order. The pipeline consists
// mostly of the base-field exponentiation, a chain of 31 modular multipliers,
// between the norm and final multiply stages. The whole pipeline holds when
// a finished result is not taken; a zero element returns all zeros.
module quartic_ext_field_inverse (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           s_axis_tvalid,
    output logic          s_axis_tready,
    input  wire  [127:0]  s_axis_tdata,   // coef0, coef1, coef2, coef3, zero pad
    input  wire  [1:0]    s_axis_tuser,   // coordinate
    output logic          m_axis_tvalid,
    input  wire           m_axis_tready,
    output logic [159:0]  m_axis_tdata    // inv0, inv1, inv2, inv3, selected_value, pad
);
    import qefi_pkg::*;

    logic [PIPE_LAT-1:0] r_vld;
    logic                w_en;
    t_elem               r_in;
    t_elem               r_a;
    t_elem               r_dly  [0:ELEM_DLY-1];
    t_norm               r_ndly [0:EXP_LAT-1];
    t_norm               w_norm;
    t_fe                 w_d, w_di;
    t_fe                 w_inv0, w_inv1, w_inv2, w_inv3, w_sel;

    assign w_en          = !r_vld[PIPE_LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in.a0    <= s_axis_tdata[30:0];
            r_in.a1    <= s_axis_tdata[61:31];
            r_in.a2    <= s_axis_tdata[92:62];
            r_in.a3    <= s_axis_tdata[123:93];
            r_in.coord <= s_axis_tuser;
            r_a.a0     <= csub(ext(r_in.a0));
            r_a.a1     <= csub(ext(r_in.a1));
            r_a.a2     <= csub(ext(r_in.a2));
            r_a.a3     <= csub(ext(r_in.a3));
            r_a.coord  <= r_in.coord;
            r_dly[0]   <= r_a;
            for (int i = 1; i < ELEM_DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
            r_ndly[0]  <= w_norm;
            for (int i = 1; i < EXP_LAT; i++) begin
                r_ndly[i] <= r_ndly[i-1];
            end
        end
    end

    qefi_norm u_norm (
        .i_clk,
        .i_en   (w_en),
        .i_elem (r_a),
        .o_norm (w_norm),
        .o_d    (w_d)
    );

    qefi_finv u_finv (
        .i_clk,
        .i_en (w_en),
        .i_d  (w_d),
        .o_di (w_di)
    );

    qefi_final u_final (
        .i_clk,
        .i_en   (w_en),
        .i_elem (r_dly[ELEM_DLY-1]),
        .i_norm (r_ndly[EXP_LAT-1]),
        .i_di   (w_di),
        .o_inv0 (w_inv0),
        .o_inv1 (w_inv1),
        .o_inv2 (w_inv2),
        .o_inv3 (w_inv3),
        .o_sel  (w_sel)
    );

    assign m_axis_tdata = {5'd0, w_sel, w_inv3, w_inv2, w_inv1, w_inv0};

endmodule
`default_nettype wire

// File: sim/quartic_ext_field_inverse_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quartic_ext_field_inverse_tb
// Self-checking bench for the GF(p^4) inverse stream. A local predictor
// computes each inverse with 64-bit field arithmetic and a square-and-multiply
// base-field inverse. Directed corners come first, then random elements under
// several patterns of input idling and output stalls.
// ----------------------------------------------------------------------------
module quartic_ext_field_inverse_tb;
    import qefi_pkg::*;

    localparam logic [63:0] PRIME    = 64'd2130706433;
    localparam logic [63:0] NONRES   = 64'd3;
    localparam int          WDOG_MAX = 20000;

    typedef struct packed {
        t_fe picked;
        t_fe inv3;
        t_fe inv2;
        t_fe inv1;
        t_fe inv0;
    } t_inverse;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata;   // coef0, coef1, coef2, coef3, zero pad
    logic [1:0]    s_axis_tuser;   // coordinate
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [159:0]  m_axis_tdata;   // inv0, inv1, inv2, inv3, selected_value, pad

    t_inverse inverse_queue[$];
    bit       failed;
    int       idle_pct;
    int       stall_pct;
    int       quiet_cycles;

    quartic_ext_field_inverse u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [63:0] gf_mul(input logic [63:0] a, input logic [63:0] b);
        gf_mul = (a * b) % PRIME;
    endfunction

    function automatic logic [63:0] gf_add(input logic [63:0] a, input logic [63:0] b);
        gf_add = (a + b) % PRIME;
    endfunction

    function automatic logic [63:0] gf_sub(input logic [63:0] a, input logic [63:0] b);
        gf_sub = (a + PRIME - b) % PRIME;
    endfunction

    function automatic logic [63:0] gf_neg(input logic [63:0] a);
        gf_neg = (a == 0) ? 64'd0 : PRIME - a;
    endfunction

    function automatic logic [63:0] gf_recip(input logic [63:0] a);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] e;
        acc = 1;
        sq  = a;
        e   = PRIME - 2;
        while (e != 0) begin
            if (e[0]) begin
                acc = gf_mul(acc, sq);
            end
            sq = gf_mul(sq, sq);
            e  = e >> 1;
        end
        gf_recip = acc;
    endfunction

    function automatic t_inverse invert_element(input t_fe c0, input t_fe c1, input t_fe c2,
                                                input t_fe c3, input logic [1:0] coord);
        logic [63:0] a0, a1, a2, a3, n0, n1, d, di, m0, m1;
        logic [63:0] r[4];
        t_inverse    res;
        a0 = {33'd0, c0} % PRIME;
        a1 = {33'd0, c1} % PRIME;
        a2 = {33'd0, c2} % PRIME;
        a3 = {33'd0, c3} % PRIME;
        n0 = gf_sub(gf_add(gf_mul(a0, a0), gf_mul(NONRES, gf_mul(a2, a2))),
                    gf_mul(NONRES, gf_mul(2, gf_mul(a1, a3))));
        n1 = gf_sub(gf_sub(gf_mul(2, gf_mul(a0, a2)), gf_mul(a1, a1)),
                    gf_mul(NONRES, gf_mul(a3, a3)));
        d  = gf_sub(gf_mul(n0, n0), gf_mul(NONRES, gf_mul(n1, n1)));
        di = gf_recip(d);
        m0 = gf_mul(n0, di);
        m1 = gf_neg(gf_mul(n1, di));
        r[0] = gf_add(gf_mul(a0, m0), gf_mul(NONRES, gf_mul(a2, m1)));
        r[2] = gf_add(gf_mul(a0, m1), gf_mul(a2, m0));
        r[1] = gf_neg(gf_add(gf_mul(a1, m0), gf_mul(NONRES, gf_mul(a3, m1))));
        r[3] = gf_neg(gf_add(gf_mul(a1, m1), gf_mul(a3, m0)));
        res.inv0   = r[0][30:0];
        res.inv1   = r[1][30:0];
        res.inv2   = r[2][30:0];
        res.inv3   = r[3][30:0];
        res.picked = r[coord][30:0];
        invert_element = res;
    endfunction

    task automatic send_element(input t_fe c0, input t_fe c1, input t_fe c2, input t_fe c3,
                                input logic [1:0] coord);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, c3, c2, c1, c0};
        s_axis_tuser  <= coord;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        inverse_queue.push_back(invert_element(c0, c1, c2, c3, coord));
        @(negedge i_clk);
    endtask

    function automatic t_fe rand_coef();
        case ($urandom_range(7))
            0: rand_coef = 31'($urandom_range(3));
            1: rand_coef = 31'(PRIME - 64'd1 - $urandom_range(2));
            2: rand_coef = 31'(PRIME + $urandom_range(16777214));
            3: rand_coef = 31'h7FFFFFFF - 31'($urandom_range(3));
            4: rand_coef = 31'd0;
            default: rand_coef = 31'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_element(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                         2'($urandom_range(3)));
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (inverse_queue.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic test_corners();
        t_fe pm1;
        t_fe big;
        pm1 = 31'(PRIME - 1);
        big = 31'h7FFFFFFF;
        idle_pct  = 0;
        stall_pct = 0;
        send_element(0, 0, 0, 0, 0);
        send_element(0, 0, 0, 0, 3);
        send_element(31'(PRIME), 0, 0, 0, 1);
        send_element(31'(PRIME), 31'(PRIME), 31'(PRIME), 31'(PRIME), 2);
        send_element(1, 0, 0, 0, 0);
        send_element(pm1, 0, 0, 0, 0);
        send_element(0, 1, 0, 0, 1);
        send_element(0, 0, 1, 0, 2);
        send_element(0, 0, 0, 1, 3);
        send_element(0, 0, 0, pm1, 3);
        send_element(pm1, pm1, pm1, pm1, 1);
        send_element(big, big, big, big, 0);
        send_element(big, 0, big, 0, 2);
        send_element(0, big, 0, big, 3);
        send_element(1, 1, 1, 1, 0);
        send_element(1, 2, 3, 4, 1);
        send_element(31'h2AAAAAAA, 31'h55555555, 31'h2AAAAAAA, 31'h55555555, 2);
        send_element(31'h55555555, 31'h2AAAAAAA, 31'h55555555, 31'h2AAAAAAA, 3);
        send_element(31'(PRIME + 1), 31'(PRIME + 2), 0, 0, 0);
    endtask

    task automatic test_streaming(input int send_idle, input int recv_stall, input int count);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        send_random(count);
    endtask

    task automatic test_pause_until_drained();
        idle_pct  = 0;
        stall_pct = 30;
        send_random(20);
        wait_drained();
        send_random(20);
    endtask

    always @(posedge i_clk) begin
        t_inverse got;
        t_inverse want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[154:0];
            if (inverse_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                failed = 1'b1;
            end else begin
                want = inverse_queue.pop_front();
                if (got.inv0 !== want.inv0) begin
                    $display("%0t: inv0 expected %0d actual %0d", $time, want.inv0, got.inv0);
                    failed = 1'b1;
                end
                if (got.inv1 !== want.inv1) begin
                    $display("%0t: inv1 expected %0d actual %0d", $time, want.inv1, got.inv1);
                    failed = 1'b1;
                end
                if (got.inv2 !== want.inv2) begin
                    $display("%0t: inv2 expected %0d actual %0d", $time, want.inv2, got.inv2);
                    failed = 1'b1;
                end
                if (got.inv3 !== want.inv3) begin
                    $display("%0t: inv3 expected %0d actual %0d", $time, want.inv3, got.inv3);
                    failed = 1'b1;
                end
                if (got.picked !== want.picked) begin
                    $display("%0t: selected_value expected %0d actual %0d", $time,
                             want.picked, got.picked);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_pct == 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        failed        = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        quiet_cycles  = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b1;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_corners();
        test_streaming(0, 0, 300);
        test_streaming(45, 0, 250);
        test_streaming(0, 45, 250);
        test_streaming(18, 18, 250);
        test_pause_until_drained();
        test_streaming(0, 0, 150);
        wait_drained();
        repeat (PIPE_LAT + 20) @(negedge i_clk);
        if (!failed && inverse_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
design/qefi_pkg.sv
design/qefi_modmul.sv
design/qefi_norm.sv
design/qefi_finv.sv
design/qefi_final.sv
design/quartic_ext_field_inverse.sv
sim/quartic_ext_field_inverse_tb.sv
